>>> rtl/core/vie_pkg.sv
// Shared types, constants and arithmetic helpers for the velocity estimate filter.
// Used by every module of the block; depends on nothing else.
package vie_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned SRC_W    = 33;
    localparam int unsigned MUL_W    = 33;
    localparam int unsigned PROD_W   = 66;
    localparam int unsigned ACC_W    = 60;
    localparam int unsigned MAX_AXES = 3;
    localparam int unsigned IN_W     = 96;
    localparam int unsigned OUT_W    = 192;
    localparam int unsigned PADDR_W  = 3;

    // Unit codes held in the units register.
    localparam logic [1:0] UNITS_MM = 2'd0;
    localparam logic [1:0] UNITS_CM = 2'd1;
    localparam logic [1:0] UNITS_DM = 2'd2;
    localparam logic [1:0] UNITS_M  = 2'd3;

    // Register index of the units register (byte address 4 * index).
    localparam logic REG_UNITS = 1'b0;

    // Filter coefficients over the common denominator of ten million.
    localparam logic signed [MUL_W-1:0] COEF_R_OUTER = 33'sd2196;
    localparam logic signed [MUL_W-1:0] COEF_R_INNER = 33'sd6588;
    localparam logic signed [MUL_W-1:0] COEF_F1      = 33'sd27488000;
    localparam logic signed [MUL_W-1:0] COEF_F2      = -33'sd25282000;
    localparam logic signed [MUL_W-1:0] COEF_F3      = 33'sd7776000;

    // Division of the filter sum by ten million: reciprocal estimate then fix-up.
    localparam logic signed [MUL_W-1:0] DIV_DEN   = 33'sd10000000;
    localparam logic signed [MUL_W-1:0] DIV_MAGIC = 33'sd3602879701;
    localparam logic [ACC_W-1:0]        DIV_HALF  = 60'd5000000;
    localparam int unsigned             DIV_SAT_BIT = 55;
    localparam int unsigned             DIV_HI_LSB  = 24;
    localparam int unsigned             DIV_Q_LSB   = 31;
    localparam int unsigned             REM_W       = 27;
    localparam logic [REM_W-1:0] REM_1 = 27'd10000000;
    localparam logic [REM_W-1:0] REM_2 = 27'd20000000;
    localparam logic [REM_W-1:0] REM_3 = 27'd30000000;
    localparam logic [REM_W-1:0] REM_4 = 27'd40000000;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_POS_MUL,
        STEP_POS_FIN,
        STEP_RAW,
        STEP_MAC_RS,
        STEP_MAC_R01,
        STEP_MAC_F0,
        STEP_MAC_F1,
        STEP_MAC_F2,
        STEP_ACC_END,
        STEP_DIV_EST,
        STEP_DIV_BACK,
        STEP_DIV_FIX,
        STEP_OUT
    } vie_step_t;

    typedef struct packed {
        vie_step_t  step;
        logic       load;
        logic [1:0] units;
    } vie_ctrl_t;

    // Reciprocal of the unit divisor, used as (x * magic) >> shift.
    function automatic logic signed [MUL_W-1:0] pos_magic(input logic [1:0] u);
        logic signed [MUL_W-1:0] m;
        case (u)
            UNITS_CM: m = 33'sd3435973837;
            UNITS_DM: m = 33'sd1374389535;
            UNITS_M:  m = 33'sd274877907;
            default:  m = '0;
        endcase
        return m;
    endfunction

    // Half the unit divisor, added to the magnitude for round-half-away.
    function automatic logic [DATA_W-1:0] pos_half(input logic [1:0] u);
        logic [DATA_W-1:0] h;
        case (u)
            UNITS_CM: h = 32'd5;
            UNITS_DM: h = 32'd50;
            UNITS_M:  h = 32'd500;
            default:  h = 32'd0;
        endcase
        return h;
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic [DATA_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = S32_MAX;
        end else if (v < -64'sd2147483648) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/vie_lane.sv
// One axis of the velocity estimator: position scaling, backward difference and IIR.
// Holds the axis histories and a shared 33x33 multiplier; depends on vie_pkg.
module vie_lane (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  vie_pkg::vie_ctrl_t              ctrl,
    input  logic signed [vie_pkg::SRC_W-1:0] src,
    output logic [vie_pkg::DATA_W-1:0]      pos_o,
    output logic [vie_pkg::DATA_W-1:0]      vel_o
);
    import vie_pkg::*;

    logic signed [SRC_W-1:0]  src_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [DATA_W-1:0]        pos_reg;
    logic [DATA_W-1:0]        raw_reg;
    logic [DATA_W-1:0]        vel_reg;
    logic [DATA_W-1:0]        qest_reg;
    logic [REM_W-1:0]         alow_reg;
    logic                     neg_reg;
    logic                     big_reg;
    logic [DATA_W-1:0]        ph0_reg, ph1_reg;
    logic [DATA_W-1:0]        rh0_reg, rh1_reg, rh2_reg;
    logic [DATA_W-1:0]        fh0_reg, fh1_reg, fh2_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_next;

    logic                     src_neg;
    logic [SRC_W-1:0]         src_mag;
    logic [DATA_W-1:0]        pos_x;
    logic [DATA_W-1:0]        pos_q;
    logic signed [SRC_W-1:0]  pos_s;
    logic [DATA_W-1:0]        pos_val;

    logic signed [35:0]       p36, ph0_36, ph1_36, diff;
    logic signed [44:0]       d45, raw45;
    logic [DATA_W-1:0]        raw_val;

    logic [ACC_W-1:0]         acc_mag;
    logic [ACC_W-1:0]         a_rnd;
    logic                     big_next;
    logic [DIV_SAT_BIT-DIV_HI_LSB-1:0] a_hi;
    logic [DATA_W-1:0]        qest;
    logic [REM_W-1:0]         rem;
    logic [2:0]               fix_cnt;
    logic [SRC_W-1:0]         q_fix;
    logic [SRC_W-1:0]         q_neg;
    logic [DATA_W-1:0]        vel_val;

    assign prod_next = mul_a * mul_b;

    // Position: magnitude plus half the divisor, then a reciprocal multiply.
    assign src_neg = src_reg[SRC_W-1];
    assign src_mag = src_neg ? $unsigned(-src_reg) : $unsigned(src_reg);
    assign pos_x   = src_mag[DATA_W-1:0] + pos_half(ctrl.units);

    always_comb begin
        case (ctrl.units)
            UNITS_CM: pos_q = {1'b0, prod_reg[65:35]};
            UNITS_DM: pos_q = {3'b0, prod_reg[65:37]};
            UNITS_M:  pos_q = {4'b0, prod_reg[65:38]};
            default:  pos_q = pos_x;
        endcase
    end

    assign pos_s   = src_neg ? -$signed({1'b0, pos_q}) : $signed({1'b0, pos_q});
    assign pos_val = sat32({{31{pos_s[SRC_W-1]}}, pos_s});

    // Raw velocity (3p - 4p1 + p2) * 500, the constant built from shifts.
    assign p36    = {{4{pos_reg[DATA_W-1]}}, pos_reg};
    assign ph0_36 = {{4{ph0_reg[DATA_W-1]}}, ph0_reg};
    assign ph1_36 = {{4{ph1_reg[DATA_W-1]}}, ph1_reg};
    assign diff   = (p36 <<< 1) + p36 - (ph0_36 <<< 2) + ph1_36;
    assign d45    = {{9{diff[35]}}, diff};
    assign raw45  = (d45 <<< 9) - (d45 <<< 3) - (d45 <<< 2);
    assign raw_val = sat32({{19{raw45[44]}}, raw45});

    // Filter sum divided by ten million, rounded half away from zero.
    assign acc_mag  = acc_reg[ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign a_rnd    = acc_mag + DIV_HALF;
    assign big_next = |a_rnd[ACC_W-1:DIV_SAT_BIT];
    assign a_hi     = a_rnd[DIV_SAT_BIT-1:DIV_HI_LSB];
    assign qest     = prod_reg[DIV_Q_LSB+DATA_W-1:DIV_Q_LSB];
    assign rem      = alow_reg - prod_reg[REM_W-1:0];
    assign fix_cnt  = 3'(rem >= REM_1) + 3'(rem >= REM_2) + 3'(rem >= REM_3)
                    + 3'(rem >= REM_4);
    assign q_fix    = {1'b0, qest_reg} + {30'b0, fix_cnt};
    assign q_neg    = -q_fix;

    always_comb begin
        if (big_reg) begin
            vel_val = neg_reg ? S32_MIN : S32_MAX;
        end else if (neg_reg) begin
            vel_val = (q_fix > 33'h0_8000_0000) ? S32_MIN : q_neg[DATA_W-1:0];
        end else begin
            vel_val = (q_fix > 33'h0_7FFF_FFFF) ? S32_MAX : q_fix[DATA_W-1:0];
        end
    end

    // Multiplier operand selection per step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.step)
            STEP_POS_MUL: begin
                mul_a = $signed({1'b0, pos_x});
                mul_b = pos_magic(ctrl.units);
            end
            STEP_MAC_RS: begin
                mul_a = $signed({raw_reg[DATA_W-1], raw_reg})
                      + $signed({rh2_reg[DATA_W-1], rh2_reg});
                mul_b = COEF_R_OUTER;
            end
            STEP_MAC_R01: begin
                mul_a = $signed({rh0_reg[DATA_W-1], rh0_reg})
                      + $signed({rh1_reg[DATA_W-1], rh1_reg});
                mul_b = COEF_R_INNER;
            end
            STEP_MAC_F0: begin
                mul_a = $signed({fh0_reg[DATA_W-1], fh0_reg});
                mul_b = COEF_F1;
            end
            STEP_MAC_F1: begin
                mul_a = $signed({fh1_reg[DATA_W-1], fh1_reg});
                mul_b = COEF_F2;
            end
            STEP_MAC_F2: begin
                mul_a = $signed({fh2_reg[DATA_W-1], fh2_reg});
                mul_b = COEF_F3;
            end
            STEP_DIV_EST: begin
                mul_a = $signed({2'b0, a_hi});
                mul_b = DIV_MAGIC;
            end
            STEP_DIV_BACK: begin
                mul_a = $signed({1'b0, qest});
                mul_b = DIV_DEN;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        case (ctrl.step)
            STEP_IDLE: begin
                if (ctrl.load) begin
                    src_reg <= src;
                end
            end
            STEP_POS_FIN:  pos_reg <= pos_val;
            STEP_RAW:      raw_reg <= raw_val;
            STEP_MAC_R01:  acc_reg <= prod_reg[ACC_W-1:0];
            STEP_MAC_F0,
            STEP_MAC_F1,
            STEP_MAC_F2,
            STEP_ACC_END:  acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            STEP_DIV_EST: begin
                neg_reg  <= acc_reg[ACC_W-1];
                big_reg  <= big_next;
                alow_reg <= a_rnd[REM_W-1:0];
            end
            STEP_DIV_BACK: qest_reg <= qest;
            STEP_DIV_FIX:  vel_reg  <= vel_val;
            default: ;
        endcase
    end

    // Histories are shifted once per item, when the filtered value is known.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph0_reg <= '0;
            ph1_reg <= '0;
            rh0_reg <= '0;
            rh1_reg <= '0;
            rh2_reg <= '0;
            fh0_reg <= '0;
            fh1_reg <= '0;
            fh2_reg <= '0;
        end else if (ctrl.step == STEP_DIV_FIX) begin
            ph1_reg <= ph0_reg;
            ph0_reg <= pos_reg;
            rh2_reg <= rh1_reg;
            rh1_reg <= rh0_reg;
            rh0_reg <= raw_reg;
            fh2_reg <= fh1_reg;
            fh1_reg <= fh0_reg;
            fh0_reg <= vel_val;
        end
    end

    assign pos_o = pos_reg;
    assign vel_o = vel_reg;

`ifndef SYNTHESIS
    // The quotient estimate is never more than three short of the true quotient.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step == STEP_DIV_FIX && !big_reg) |-> (rem < REM_4))
        else $error("vie_lane: division fix-up out of range");

    // The scaled estimate fits in 32 bits once saturation has been ruled out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step == STEP_DIV_BACK) |-> (prod_reg[PROD_W-1:DIV_Q_LSB+DATA_W] == '0))
        else $error("vie_lane: quotient estimate overflow");

    // A scaled position magnitude never exceeds two to the 31.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step == STEP_POS_FIN) |-> (pos_q <= 32'h8000_0000))
        else $error("vie_lane: position quotient out of range");
`endif

endmodule

>>> rtl/core/vie_ctrl.sv
// Step sequencer shared by all lanes of the velocity estimate filter.
// Drives the lane control struct and the output load; depends on vie_pkg.
module vie_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         units,
    input  logic               out_free,
    output vie_pkg::vie_ctrl_t ctrl,
    output logic               out_load
);
    import vie_pkg::*;

    vie_step_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STEP_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            STEP_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = STEP_POS_MUL;
                end
            end
            STEP_POS_MUL:  state_next = STEP_POS_FIN;
            STEP_POS_FIN:  state_next = STEP_RAW;
            STEP_RAW:      state_next = STEP_MAC_RS;
            STEP_MAC_RS:   state_next = STEP_MAC_R01;
            STEP_MAC_R01:  state_next = STEP_MAC_F0;
            STEP_MAC_F0:   state_next = STEP_MAC_F1;
            STEP_MAC_F1:   state_next = STEP_MAC_F2;
            STEP_MAC_F2:   state_next = STEP_ACC_END;
            STEP_ACC_END:  state_next = STEP_DIV_EST;
            STEP_DIV_EST:  state_next = STEP_DIV_BACK;
            STEP_DIV_BACK: state_next = STEP_DIV_FIX;
            STEP_DIV_FIX:  state_next = STEP_OUT;
            STEP_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = STEP_IDLE;
                end
            end
            default: state_next = STEP_IDLE;
        endcase
    end

    assign ctrl.step  = state_reg;
    assign ctrl.load  = s_tvalid && s_tready;
    assign ctrl.units = units;

`ifndef SYNTHESIS
    // Work only starts on an accepted item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == STEP_POS_MUL) |-> $past(s_tvalid && s_tready))
        else $error("vie_ctrl: sequence started without an item");

    // A finished item waits while the output register is still occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == STEP_OUT && !out_free) |=> (state_reg == STEP_OUT))
        else $error("vie_ctrl: result dropped under back-pressure");

    // Handing over the result frees the lanes for the next item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (state_reg == STEP_IDLE))
        else $error("vie_ctrl: lanes not released after output load");
`endif

endmodule

>>> rtl/core/vie_merge.sv
// Merging stage: packs the lane results into one output item and holds it
// in the output register until taken. Depends on vie_pkg.
module vie_merge (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              load,
    input  logic [vie_pkg::MAX_AXES-1:0][vie_pkg::DATA_W-1:0] pos_i,
    input  logic [vie_pkg::MAX_AXES-1:0][vie_pkg::DATA_W-1:0] vel_i,
    output logic                                              out_free,
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    output logic [vie_pkg::OUT_W-1:0]                         m_tdata
);
    import vie_pkg::*;

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] tdata_reg;
    logic [OUT_W-1:0] tdata_next;

    // Positions in the lower half, velocities above them, axis x lowest.
    always_comb begin
        tdata_next = '0;
        for (int a = 0; a < MAX_AXES; a++) begin
            tdata_next[a*DATA_W +: DATA_W]              = pos_i[a];
            tdata_next[(MAX_AXES+a)*DATA_W +: DATA_W]   = vel_i[a];
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tdata_reg;

endmodule

>>> rtl/core/velocity_estimate_iir_filter_core.sv
// Top level of the velocity estimate filter: APB units register, input remap,
// one lane per axis, sequencer and merging stage. Depends on vie_pkg and all vie_ modules.
//
// Usage. Each servo tick sends one item on the s_ channel carrying the device
// translation (x, y, z) in Q15.16 millimetres. The block remaps the axes to
// (x, -z, y), divides by the unit ratio held in the units register, forms a
// three-point backward-difference velocity per axis and smooths it with a fixed
// third-order IIR filter. One result item leaves on the m_ channel per input
// item, carrying the scaled positions and the filtered velocities.
// Timing. Every axis lane steps through the same step sequence on its own
// 33x33 multiplier (scale, difference, five multiply-accumulates, two-multiply
// division by ten million); the result is then loaded into the output register
// from the final step before the sequencer returns to idle, so the block takes a
// new item only once it is through with the last one.
// Stalls. A result waits in the output register while m_tready is low; the
// block still accepts and works on the next item, and holds that one in its
// final step until the register is free.
// Reset. aresetn low clears all position and velocity histories, sets the unit
// to millimetres and empties the output register.
// The units register lies at byte address 0 and must only be written while idle.
module velocity_estimate_iir_filter_core #(
    parameter int unsigned AXES = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vie_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: device_x [31:0], device_y [63:32], device_z [95:64]
    input  logic [vie_pkg::IN_W-1:0]      s_tdata,
    // Result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64],
    //          vel_x [127:96], vel_y [159:128], vel_z [191:160]
    output logic [vie_pkg::OUT_W-1:0]     m_tdata
);
    import vie_pkg::*;

    logic [1:0]  units_reg;
    logic        cfg_write;
    vie_ctrl_t   ctrl;
    logic        out_free;
    logic        out_load;

    logic signed [MAX_AXES-1:0][SRC_W-1:0]  src;
    logic [MAX_AXES-1:0][DATA_W-1:0]        lane_pos;
    logic [MAX_AXES-1:0][DATA_W-1:0]        lane_vel;

    // Configuration register. Writes complete in the APB access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            units_reg <= UNITS_MM;
        end else if (cfg_write && paddr[PADDR_W-1:2] == REG_UNITS) begin
            units_reg <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_UNITS) ? {30'b0, units_reg} : 32'b0;

    // Axis remap: lane 0 takes x, lane 1 takes minus z, lane 2 takes y. Minus z
    // needs the 33rd bit for the most negative input.
    assign src[0] = $signed({s_tdata[31], s_tdata[31:0]});
    assign src[1] = -$signed({s_tdata[95], s_tdata[95:64]});
    assign src[2] = $signed({s_tdata[63], s_tdata[63:32]});

    vie_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .units    (units_reg),
        .out_free (out_free),
        .ctrl     (ctrl),
        .out_load (out_load)
    );

    // One lane per used axis; the fields of missing axes read as zero.
    for (genvar a = 0; a < MAX_AXES; a++) begin : g_lane
        if (a < AXES) begin : g_used
            vie_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .src     (src[a]),
                .pos_o   (lane_pos[a]),
                .vel_o   (lane_vel[a])
            );
        end else begin : g_unused
            assign lane_pos[a] = '0;
            assign lane_vel[a] = '0;
        end
    end

    vie_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .pos_i    (lane_pos),
        .vel_i    (lane_vel),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
